@@ design/crtcbr_pkg.sv @@
package crtcbr_pkg;

    // CRTC register file geometry.
    localparam int CRTC_COUNT = 64;
    localparam int CRTC_IDX_W = $clog2(CRTC_COUNT);

    // Bus access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // I/O ports handled here, after the mono/color remap.
    localparam logic [15:0] PORT_BANK      = 16'h03CD;
    localparam logic [15:0] PORT_GFX_INDEX = 16'h03CE;
    localparam logic [15:0] PORT_GFX_DATA  = 16'h03CF;
    localparam logic [15:0] PORT_CRTC_IDX  = 16'h03D4;
    localparam logic [15:0] PORT_CRTC_DATA = 16'h03D5;
    localparam logic [11:0] PORT_MONO_BLK  = 12'h03B;
    localparam logic [11:0] PORT_COLOR_BLK = 12'h03D;
    localparam logic [15:0] PORT_SWAP_MASK = 16'h0060;

    // CRTC register numbers with special behavior.
    localparam logic [CRTC_IDX_W-1:0] CRTC_OVERFLOW   = 6'h07;
    localparam logic [CRTC_IDX_W-1:0] CRTC_PROT_LIMIT = 6'h07;
    localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_LO  = 6'h0E;
    localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_HI  = 6'h10;
    localparam logic [CRTC_IDX_W-1:0] CRTC_VRETRACE   = 6'h11;
    localparam logic [CRTC_IDX_W-1:0] CRTC_EXT_PROT   = 6'h35;
    localparam logic [CRTC_IDX_W-1:0] CRTC_EXT_CTL    = 6'h36;
    localparam logic [CRTC_IDX_W-1:0] CRTC_MEM_CFG    = 6'h37;

    // Graphics controller register that holds the memory map.
    localparam logic [3:0] GFX_MODE_INDEX = 4'h6;

    // Board variant that skips the memory size check.
    localparam logic [1:0] BOARD_NO_SIZE_CHECK = 2'd1;

    // Configuration register numbers.
    localparam logic [1:0] CFG_COLOR   = 2'd0;
    localparam logic [1:0] CFG_VARIANT = 2'd1;
    localparam logic [1:0] CFG_MEMSIZE = 2'd2;

    // Write request into the CRTC register file.
    typedef struct packed {
        logic                  we;
        logic [CRTC_IDX_W-1:0] addr;
        logic [7:0]            data;
    } crtc_wr_t;

    // Values the register file presents to the access logic.
    typedef struct packed {
        logic [7:0] cur;
        logic [7:0] ctl11;
        logic [7:0] ext36;
    } crtc_rd_t;

    // Bits of each CRTC register that are implemented.
    function automatic logic [7:0] reg_mask(input logic [CRTC_IDX_W-1:0] idx);
        logic [7:0] m;
        if (idx <= 6'h18) begin
            m = 8'hFF;
        end
        else if (idx < 6'h30) begin
            m = 8'h00;
        end
        else if (idx == 6'h33) begin
            m = 8'h0F;
        end
        else if (idx < 6'h38) begin
            m = 8'hFF;
        end
        else begin
            m = 8'h00;
        end
        return m;
    endfunction

    // Memory size code that a CRTC 0x37 setting requires.
    function automatic logic [2:0] size_needed(input logic [7:0] v);
        logic [2:0] s;
        case (v[3:0] & 4'hB)
            4'h0, 4'h1:       s = 3'd0;
            4'h2:             s = 3'd1;
            4'h3, 4'h8, 4'h9: s = 3'd2;
            4'hA:             s = 3'd3;
            default:          s = 3'd4;
        endcase
        return s;
    endfunction

endpackage

@@ design/svga_crtc_extension_and_bank_regs_unit.sv @@
// A transaction accepted at a clock edge is captured in the input stage; done and
// the result fields are then registered from that stage.
// Throughput: one transaction per cycle; busy is never asserted, and the
// receiver cannot stall, so results leave as fast as they are produced.
// Reset: rst_n is asynchronous and active low; all CRTC registers read as zero
// immediately after reset through per-register valid bits.
module svga_crtc_extension_and_bank_regs_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] port_address,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        forwarded,
    output logic [3:0]  bank_wr,
    output logic [3:0]  bank_rd,
    output logic        linear_window,
    output logic        timing_change,
    output logic        memory_map_on,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic       color_reg;
    logic [1:0] variant_reg;
    logic [2:0] memsize_reg;
    logic       cfg_we;

    // Input stage.
    logic        item_valid_reg;
    logic        op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // Block state.
    logic [crtcbr_pkg::CRTC_IDX_W-1:0] crtc_index_reg, crtc_index_next;
    logic [7:0] bank_sel_reg, bank_sel_next;
    logic [3:0] gfx_index_reg, gfx_index_next;
    logic [7:0] gfx_mode_reg, gfx_mode_next;
    logic [3:0] wbank_reg, wbank_next;
    logic [3:0] rbank_reg, rbank_next;
    logic       linear_reg, linear_next;
    logic       map_on_reg, map_on_next;

    // Result stage.
    logic       done_reg;
    logic [7:0] rd_res_reg;
    logic       fwd_res_reg;
    logic       tchg_res_reg;
    logic [7:0] rd_val;
    logic       fwd_val;
    logic       tchg_val;

    // Access decode working values.
    logic [15:0] eff_addr;
    logic        prot;
    logic [7:0]  crtc_val;

    crtcbr_pkg::crtc_wr_t crtc_wr;
    crtcbr_pkg::crtc_rd_t crtc_rd;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Configuration write and read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg   <= 1'b1;
            variant_reg <= 2'd0;
            memsize_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                crtcbr_pkg::CFG_COLOR:   color_reg   <= pwdata[0];
                crtcbr_pkg::CFG_VARIANT: variant_reg <= pwdata[1:0];
                crtcbr_pkg::CFG_MEMSIZE: memsize_reg <= pwdata[2:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            crtcbr_pkg::CFG_COLOR:   prdata = {31'd0, color_reg};
            crtcbr_pkg::CFG_VARIANT: prdata = {30'd0, variant_reg};
            crtcbr_pkg::CFG_MEMSIZE: prdata = {29'd0, memsize_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Input register for each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= opcode;
            addr_reg <= port_address;
            data_reg <= write_data;
        end
    end

    crtcbr_crtc_file u_crtc_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (crtc_wr),
        .rd_addr (crtc_index_next),
        .rd      (crtc_rd)
    );

    // Port decode and register updates for the transaction in the input stage.
    always_comb
    begin
        crtc_index_next = crtc_index_reg;
        bank_sel_next   = bank_sel_reg;
        gfx_index_next  = gfx_index_reg;
        gfx_mode_next   = gfx_mode_reg;
        wbank_next      = wbank_reg;
        rbank_next      = rbank_reg;
        linear_next     = linear_reg;
        map_on_next     = map_on_reg;
        rd_val          = 8'h00;
        fwd_val         = 1'b1;
        tchg_val        = 1'b0;
        crtc_wr.we      = 1'b0;
        crtc_wr.addr    = crtc_index_reg;
        crtc_val        = data_reg;
        prot            = crtc_rd.ctl11[7];

        // Mono and color port blocks swap when color addressing is off.
        eff_addr = addr_reg;
        if ((addr_reg[15:4] == crtcbr_pkg::PORT_COLOR_BLK
             || addr_reg[15:4] == crtcbr_pkg::PORT_MONO_BLK) && !color_reg)
        begin
            eff_addr = addr_reg ^ crtcbr_pkg::PORT_SWAP_MASK;
        end

        // Value a CRTC data write would store.
        if (crtc_index_reg == crtcbr_pkg::CRTC_OVERFLOW && prot)
        begin
            crtc_val = (crtc_rd.cur & 8'hEF) | (data_reg & 8'h10);
        end
        crtc_val = crtc_val & crtcbr_pkg::reg_mask(crtc_index_reg);
        crtc_wr.data = crtc_val;

        if (item_valid_reg)
        begin
            if (op_reg == crtcbr_pkg::OP_READ)
            begin
                if (eff_addr == crtcbr_pkg::PORT_BANK)
                begin
                    rd_val  = bank_sel_reg;
                    fwd_val = 1'b0;
                end
                else if (eff_addr == crtcbr_pkg::PORT_CRTC_IDX)
                begin
                    rd_val  = {2'b00, crtc_index_reg};
                    fwd_val = 1'b0;
                end
                else if (eff_addr == crtcbr_pkg::PORT_CRTC_DATA)
                begin
                    rd_val  = crtc_rd.cur;
                    fwd_val = 1'b0;
                end
            end
            else if (eff_addr == crtcbr_pkg::PORT_BANK)
            begin
                bank_sel_next = data_reg;
                if (!crtc_rd.ext36[4] && !gfx_mode_reg[3])
                begin
                    wbank_next = data_reg[3:0];
                    rbank_next = data_reg[7:4];
                end
                fwd_val = 1'b0;
            end
            else if (eff_addr == crtcbr_pkg::PORT_GFX_INDEX)
            begin
                gfx_index_next = data_reg[3:0];
            end
            else if (eff_addr == crtcbr_pkg::PORT_GFX_DATA)
            begin
                if (gfx_index_reg == crtcbr_pkg::GFX_MODE_INDEX)
                begin
                    if (!crtc_rd.ext36[4] && !data_reg[3])
                    begin
                        wbank_next = bank_sel_reg[3:0];
                        rbank_next = bank_sel_reg[7:4];
                    end
                    else
                    begin
                        wbank_next = 4'd0;
                        rbank_next = 4'd0;
                    end
                    gfx_mode_next = data_reg;
                    linear_next   = (gfx_mode_reg[3:2] != 2'b00) && (data_reg[3:2] == 2'b00);
                end
            end
            else if (eff_addr == crtcbr_pkg::PORT_CRTC_IDX)
            begin
                crtc_index_next = data_reg[crtcbr_pkg::CRTC_IDX_W-1:0];
                fwd_val         = 1'b0;
            end
            else if (eff_addr == crtcbr_pkg::PORT_CRTC_DATA)
            begin
                if (prot && (crtc_index_reg < crtcbr_pkg::CRTC_PROT_LIMIT
                             || crtc_index_reg == crtcbr_pkg::CRTC_EXT_PROT))
                begin
                    fwd_val = 1'b0;
                end
                else
                begin
                    crtc_wr.we = 1'b1;
                    if (crtc_index_reg == crtcbr_pkg::CRTC_EXT_CTL)
                    begin
                        if (!crtc_val[4] && !gfx_mode_reg[3])
                        begin
                            wbank_next = bank_sel_reg[3:0];
                            rbank_next = bank_sel_reg[7:4];
                        end
                        else
                        begin
                            wbank_next = 4'd0;
                            rbank_next = 4'd0;
                        end
                    end
                    tchg_val = (crtc_rd.cur != crtc_val)
                               && (crtc_index_reg < crtcbr_pkg::CRTC_CURSOR_LO
                                   || crtc_index_reg > crtcbr_pkg::CRTC_CURSOR_HI);
                    if (crtc_index_reg == crtcbr_pkg::CRTC_MEM_CFG
                        && variant_reg != crtcbr_pkg::BOARD_NO_SIZE_CHECK)
                    begin
                        map_on_next = (crtcbr_pkg::size_needed(crtc_val) == memsize_reg);
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crtc_index_reg <= '0;
            bank_sel_reg   <= 8'h00;
            gfx_index_reg  <= 4'h0;
            gfx_mode_reg   <= 8'h00;
            wbank_reg      <= 4'h0;
            rbank_reg      <= 4'h0;
            linear_reg     <= 1'b0;
            map_on_reg     <= 1'b1;
            done_reg       <= 1'b0;
        end
        else
        begin
            crtc_index_reg <= crtc_index_next;
            bank_sel_reg   <= bank_sel_next;
            gfx_index_reg  <= gfx_index_next;
            gfx_mode_reg   <= gfx_mode_next;
            wbank_reg      <= wbank_next;
            rbank_reg      <= rbank_next;
            linear_reg     <= linear_next;
            map_on_reg     <= map_on_next;
            done_reg       <= item_valid_reg;
        end
    end

    // Result register for the per-transaction fields.
    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            rd_res_reg   <= rd_val;
            fwd_res_reg  <= fwd_val;
            tchg_res_reg <= tchg_val;
        end
    end

    assign done          = done_reg;
    assign read_data     = rd_res_reg;
    assign forwarded     = fwd_res_reg;
    assign timing_change = tchg_res_reg;
    assign bank_wr       = wbank_reg;
    assign bank_rd       = rbank_reg;
    assign linear_window = linear_reg;
    assign memory_map_on = map_on_reg;

    // A result appears only for a transaction held in the input stage.
    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_valid_reg))
        else $error("done without a transaction in the input stage");

    // Data returned by a handled read is never forwarded as well.
    a_read_not_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_data != 8'h00) |-> !forwarded)
        else $error("read data returned on a forwarded access");

    // Linear addressing or the extended control bit keeps both banks at zero.
    a_banks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (gfx_mode_reg[3] || crtc_rd.ext36[4]) |-> (wbank_reg == 4'd0 && rbank_reg == 4'd0))
        else $error("bank nonzero while banking is disabled");

endmodule

@@ design/crtcbr_crtc_file.sv @@
module crtcbr_crtc_file (
    input  logic                                clk,
    input  logic                                rst_n,
    input  crtcbr_pkg::crtc_wr_t                wr,
    input  logic [crtcbr_pkg::CRTC_IDX_W-1:0]   rd_addr,
    output crtcbr_pkg::crtc_rd_t                rd
);

    logic [7:0]                        mem [crtcbr_pkg::CRTC_COUNT];
    logic [crtcbr_pkg::CRTC_COUNT-1:0] valid_reg;
    logic [7:0]                        mem_q_reg;
    logic                              rd_valid_reg;
    logic                              byp_reg;
    logic [7:0]                        byp_data_reg;
    logic [7:0]                        ctl11_reg;
    logic [7:0]                        ext36_reg;

    // Storage array with a registered read of the next selected register.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= mem[rd_addr];
        byp_data_reg <= wr.data;
    end

    // Valid bits make never-written registers read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            ctl11_reg    <= 8'h00;
            ext36_reg    <= 8'h00;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            byp_reg      <= wr.we;
            if (wr.we && wr.addr == crtcbr_pkg::CRTC_VRETRACE)
            begin
                ctl11_reg <= wr.data;
            end
            if (wr.we && wr.addr == crtcbr_pkg::CRTC_EXT_CTL)
            begin
                ext36_reg <= wr.data;
            end
        end
    end

    // A write in the previous cycle always targets the selected register.
    always_comb
    begin
        if (byp_reg)
        begin
            rd.cur = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd.cur = mem_q_reg;
        end
        else
        begin
            rd.cur = 8'h00;
        end
        rd.ctl11 = ctl11_reg;
        rd.ext36 = ext36_reg;
    end

endmodule
